FILE: src/rtsbf_pkg.sv
`timescale 1ns / 1ps
// rtsbf_pkg: shared types, constants and coding helpers of the blind frame builder.
// No dependencies; used by the register write interface and all modules.
package rtsbf_pkg;

    localparam int PAYLOAD_LEN  = 7;
    localparam int PREAMBLE_LEN = 4;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 24;
    localparam int PFX_IDX_W    = 6;

    typedef enum logic {
        OP_SEND    = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    localparam logic [CFG_IDX_W-1:0] REG_KEY  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE = 8'd1;

    localparam logic [7:0] KEY_RESET = 8'd167;

    typedef logic [PAYLOAD_LEN-1:0][7:0] frame_t;

    // Pending frame handed from the payload builder to the serializer.
    typedef struct packed {
        logic   valid;
        frame_t frame;
    } load_t;

    localparam logic [PREAMBLE_LEN-1:0][7:0] PREAMBLE = {8'hfe, 8'he1, 8'he1, 8'h01};

    function automatic logic [7:0] prefix_byte(input logic [PFX_IDX_W-1:0] i,
                                               input logic [PFX_IDX_W-1:0] n);
        logic [PFX_IDX_W-1:0] start;
        logic [PFX_IDX_W-1:0] off;
        logic [7:0]           b;
        start = n - PFX_IDX_W'(PREAMBLE_LEN);
        off   = i - start;
        if (i >= start)
            b = PREAMBLE[off[1:0]];
        else if (i < PFX_IDX_W'(2))
            b = 8'hff;
        else
            b = 8'h00;
        return b;
    endfunction

    // Bit k of the nibble becomes pair k: 1 -> 01, 0 -> 10.
    function automatic logic [7:0] code_nibble(input logic [3:0] nib);
        logic [7:0] v;
        for (int k = 0; k < 4; k++)
            v[2*k +: 2] = nib[k] ? 2'b01 : 2'b10;
        return v;
    endfunction

endpackage

FILE: src/rtsbf_in_if.sv
`timescale 1ns / 1ps
// rtsbf_in_if: request channel (send / advance words) of the blind frame builder.
// Depends on no other file.
interface rtsbf_in_if;
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [3:0]           remote_slot;
    logic [3:0]           command;

    modport source (output valid, op, remote_slot, command, input ready);
    modport sink   (input valid, op, remote_slot, command, output ready);
endinterface

FILE: src/rtsbf_out_if.sv
`timescale 1ns / 1ps
// rtsbf_out_if: frame byte channel of the blind frame builder.
// Depends on no other file.
interface rtsbf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

FILE: src/rtsbf_cfg_if.sv
`timescale 1ns / 1ps
// rtsbf_cfg_if: register write channel of the blind frame builder.
// Depends on rtsbf_pkg for the index and data widths.
interface rtsbf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rtsbf_pkg::CFG_IDX_W-1:0]  index;
    logic [rtsbf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/rtsbf_serializer.sv
`timescale 1ns / 1ps
// rtsbf_serializer: holds one built payload and streams prefix plus Manchester
// coded bytes, one per cycle unless rsp stalls, through an output register. Depends on rtsbf_pkg.
module rtsbf_serializer #(
    parameter int PREFIX_BYTES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rtsbf_pkg::load_t     load,
    output logic                 taken,
    rtsbf_out_if.source          rsp
);

    localparam int TOTAL = PREFIX_BYTES + 2 * rtsbf_pkg::PAYLOAD_LEN;
    localparam int CNT_W = $clog2(TOTAL);

    rtsbf_pkg::frame_t  frame_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               ovalid_reg;
    logic [7:0]         obyte_reg;
    logic               olast_reg;

    logic               adv;
    logic               at_end;
    logic               last_adv;
    logic [CNT_W-1:0]   off;
    logic [2:0]         pidx;
    logic [7:0]         pbyte;
    logic [7:0]         cur_byte;

    assign adv      = busy_reg && (!ovalid_reg || rsp.ready);
    assign at_end   = (cnt_reg == CNT_W'(TOTAL - 1));
    assign last_adv = adv && at_end;
    assign taken    = load.valid && (!busy_reg || last_adv);

    assign off  = cnt_reg - CNT_W'(PREFIX_BYTES);
    assign pidx = off[3:1];

    always_comb
    begin
        pbyte = frame_reg[pidx];
        if (cnt_reg < CNT_W'(PREFIX_BYTES))
            cur_byte = rtsbf_pkg::prefix_byte(rtsbf_pkg::PFX_IDX_W'(cnt_reg),
                                              rtsbf_pkg::PFX_IDX_W'(PREFIX_BYTES));
        else if (off[0] == 1'b0)
            cur_byte = rtsbf_pkg::code_nibble(pbyte[7:4]);
        else
            cur_byte = rtsbf_pkg::code_nibble(pbyte[3:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (taken)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (last_adv)
            begin
                busy_reg <= 1'b0;
            end
            else if (adv)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            if (adv)
                ovalid_reg <= 1'b1;
            else if (rsp.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (taken)
            frame_reg <= load.frame;
        if (adv)
        begin
            obyte_reg <= cur_byte;
            olast_reg <= at_end;
        end
    end

    assign rsp.valid      = ovalid_reg;
    assign rsp.frame_byte = obyte_reg;
    assign rsp.last_byte  = olast_reg;

endmodule

FILE: src/rts_blind_frame_builder_core.sv
`timescale 1ns / 1ps
// rts_blind_frame_builder_core: top level of the blind remote frame builder.
// Depends on rtsbf_pkg, rtsbf_in_if, rtsbf_out_if, rtsbf_cfg_if, rtsbf_serializer.
//
// Usage:
//   req  - valid/ready request words: op (send or advance), remote_slot, command.
//   rsp  - valid/ready frame bytes; last_byte marks the final byte of a frame.
//   cfg  - register writes (index 0 key byte, index 1 base remote id); always ready.
// A send word is built into a seven-byte payload in the accept cycle and parked
// in a one-entry pending register. The serializer takes it and emits
// PREFIX_BYTES + 14 bytes (30 by default), one per cycle unless rsp stalls; the
// first byte reaches rsp through the pending register, the serializer's busy and
// count registers and its output register. The serializer's byte stream sets the
// rate of send words, with no gap between frames. An advance word bumps the slot's
// rolling code. req.ready drops while a built frame waits for the serializer.
// When rsp stalls, the output register holds its byte and the serializer waits.
// Reset clears the rolling-code table, the key to 167 and the base id to zero,
// and drops every pending frame and byte.
module rts_blind_frame_builder_core #(
    parameter int REMOTE_SLOTS = 9,
    parameter int PREFIX_BYTES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    rtsbf_in_if.sink     req,
    rtsbf_out_if.source  rsp,
    rtsbf_cfg_if.sink    cfg
);

    localparam int SLOT_IDX_W = (REMOTE_SLOTS > 1) ? $clog2(REMOTE_SLOTS) : 1;

    logic [7:0]                 key_reg;
    logic [23:0]                base_reg;
    logic [15:0]                rc_table_reg [REMOTE_SLOTS];
    logic                       pend_valid_reg;
    rtsbf_pkg::frame_t          pend_frame_reg;

    logic                       acc;
    logic                       send_acc;
    logic                       adv_acc;
    logic                       slot_ok;
    logic [3:0]                 slot_m1;
    logic [SLOT_IDX_W-1:0]      slot_idx;
    logic [15:0]                rc;
    logic [23:0]                id;
    rtsbf_pkg::frame_t          raw;
    rtsbf_pkg::frame_t          built;
    logic [3:0]                 chk;
    rtsbf_pkg::load_t           load;
    logic                       taken;

    assign req.ready = !pend_valid_reg;
    assign cfg.ready = 1'b1;

    assign acc      = req.valid && req.ready;
    assign send_acc = acc && (req.op == rtsbf_pkg::OP_SEND);
    assign adv_acc  = acc && (req.op == rtsbf_pkg::OP_ADVANCE);

    assign slot_ok  = (req.remote_slot != 4'd0) &&
                      ({1'b0, req.remote_slot} <= 5'(REMOTE_SLOTS));
    assign slot_m1  = req.remote_slot - 4'd1;
    assign slot_idx = slot_m1[SLOT_IDX_W-1:0];

    // Build payload: checksum over all bytes, then chain each byte with the previous.
    always_comb
    begin
        rc = slot_ok ? rc_table_reg[slot_idx] : 16'd0;
        id = base_reg + {20'd0, req.remote_slot};

        raw[0] = key_reg;
        raw[1] = {req.command, 4'd0};
        raw[2] = rc[15:8];
        raw[3] = rc[7:0];
        raw[4] = id[23:16];
        raw[5] = id[15:8];
        raw[6] = id[7:0];

        chk = 4'd0;
        for (int i = 0; i < rtsbf_pkg::PAYLOAD_LEN; i++)
            chk = chk ^ raw[i][7:4] ^ raw[i][3:0];
        raw[1][3:0] = chk;

        built[0] = raw[0];
        for (int i = 1; i < rtsbf_pkg::PAYLOAD_LEN; i++)
            built[i] = built[i-1] ^ raw[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg        <= rtsbf_pkg::KEY_RESET;
            base_reg       <= '0;
            pend_valid_reg <= 1'b0;
            for (int s = 0; s < REMOTE_SLOTS; s++)
                rc_table_reg[s] <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == rtsbf_pkg::REG_KEY)
                    key_reg <= cfg.data[7:0];
                else if (cfg.index == rtsbf_pkg::REG_BASE)
                    base_reg <= cfg.data;
            end

            if (adv_acc && slot_ok)
                rc_table_reg[slot_idx] <= rc_table_reg[slot_idx] + 16'd1;

            if (send_acc)
                pend_valid_reg <= 1'b1;
            else if (taken)
                pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (send_acc)
            pend_frame_reg <= built;
    end

    assign load.valid = pend_valid_reg;
    assign load.frame = pend_frame_reg;

    rtsbf_serializer #(
        .PREFIX_BYTES (PREFIX_BYTES)
    ) u_serializer (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .taken (taken),
        .rsp   (rsp)
    );

    // The serializer only takes a frame that is really pending.
    a_take_pending: assert property (@(posedge clk) disable iff (!rst_n)
        taken |-> pend_valid_reg)
        else $error("serializer took a frame with nothing pending");

    // An accepted send always leaves a pending frame behind.
    a_send_parks: assert property (@(posedge clk) disable iff (!rst_n)
        send_acc |=> pend_valid_reg)
        else $error("send word accepted without a pending frame");

    // An advance on a valid slot bumps that slot's rolling code by one.
    a_advance_bumps: assert property (@(posedge clk) disable iff (!rst_n)
        (adv_acc && slot_ok) |=>
            rc_table_reg[$past(slot_idx)] == $past(rc_table_reg[slot_idx]) + 16'd1)
        else $error("rolling code not advanced");

    // A built frame that is still waiting is never overwritten before hand-off.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && !taken) |=> (pend_frame_reg == $past(pend_frame_reg)))
        else $error("pending frame changed before hand-off");

endmodule

FILE: bench/rts_blind_frame_builder_core_tb.sv
`timescale 1ns / 1ps
// rts_blind_frame_builder_core_tb: self-checking bench that predicts every frame byte from
// send/advance words and register writes and checks them in order under random stalls.
// Depends on rtsbf_pkg, rtsbf_in_if, rtsbf_out_if, rtsbf_cfg_if and the core RTL.
module rts_blind_frame_builder_core_tb;

    localparam int REMOTE_SLOTS = 9;
    localparam int PREFIX_LEN   = 16;
    localparam int FRAME_LEN    = PREFIX_LEN + 2 * rtsbf_pkg::PAYLOAD_LEN;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int MAX_REPORTS  = 10;

    // Sync run closing the prefix, first word in the top byte.
    localparam logic [31:0] SYNC_SEQ = 32'h01e1e1fe;

    // Indexes outside the register map; writes to them must be ignored.
    localparam logic [rtsbf_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd2;
    localparam logic [rtsbf_pkg::CFG_IDX_W-1:0] REG_TOP   = 8'hff;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_word_t;

    logic clk;
    logic rst_n;

    rtsbf_in_if  req_ch ();
    rtsbf_out_if rsp_ch ();
    rtsbf_cfg_if cfg_ch ();

    rts_blind_frame_builder_core #(
        .REMOTE_SLOTS (REMOTE_SLOTS),
        .PREFIX_BYTES (PREFIX_LEN)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // Predictor state
    logic [15:0] roll_code [1:REMOTE_SLOTS];
    logic [7:0]  key_byte;
    logic [23:0] base_id;
    frame_word_t frame_due [$];

    int unsigned err_count;
    int unsigned cycle_count;
    logic        quiet;
    logic        sink_open;
    int unsigned sink_left;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] line_code(input logic [3:0] n);
        return {~n[3], n[3], ~n[2], n[2], ~n[1], n[1], ~n[0], n[0]};
    endfunction

    function automatic logic [7:0] lead_word(input int i);
        if (i >= PREFIX_LEN - 4)
            return SYNC_SEQ[31 - 8 * (i - (PREFIX_LEN - 4)) -: 8];
        else if (i < 2)
            return 8'hff;
        return 8'h00;
    endfunction

    function automatic void queue_frame(input logic [3:0] slot, input logic [3:0] cmd);
        logic [7:0]  pl [rtsbf_pkg::PAYLOAD_LEN];
        logic [15:0] code;
        logic [23:0] id;
        logic [7:0]  chk;
        frame_word_t w;
        code = (slot >= 1 && slot <= REMOTE_SLOTS) ? roll_code[slot] : 16'h0000;
        id = base_id + 24'(slot);
        pl[0] = key_byte;
        pl[1] = {cmd, 4'h0};
        pl[2] = code[15:8];
        pl[3] = code[7:0];
        pl[4] = id[23:16];
        pl[5] = id[15:8];
        pl[6] = id[7:0];
        chk = 8'h00;
        for (int i = 0; i < rtsbf_pkg::PAYLOAD_LEN; i++)
            chk = chk ^ pl[i] ^ (pl[i] >> 4);
        pl[1][3:0] = chk[3:0];
        // chain each byte onto the already scrambled one before it
        for (int i = 1; i < rtsbf_pkg::PAYLOAD_LEN; i++)
            pl[i] = pl[i] ^ pl[i - 1];
        for (int i = 0; i < PREFIX_LEN; i++)
        begin
            w.value = lead_word(i);
            w.last  = 1'b0;
            frame_due.push_back(w);
        end
        for (int i = 0; i < rtsbf_pkg::PAYLOAD_LEN; i++)
        begin
            w.value = line_code(pl[i][7:4]);
            w.last  = 1'b0;
            frame_due.push_back(w);
            w.value = line_code(pl[i][3:0]);
            w.last  = (i == rtsbf_pkg::PAYLOAD_LEN - 1);
            frame_due.push_back(w);
        end
    endfunction

    function automatic void bump_code(input logic [3:0] slot);
        if (slot >= 1 && slot <= REMOTE_SLOTS)
            roll_code[slot] = roll_code[slot] + 16'd1;
    endfunction

    // ------------------------------------------------------------------
    // Gap shaping: mostly short, a few long
    // ------------------------------------------------------------------
    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned idle_len();
        if (quiet || $urandom_range(0, 1) == 0)
            return 0;
        return gap_len();
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_word(input rtsbf_pkg::op_t op, input logic [3:0] slot,
                             input logic [3:0] cmd);
        int unsigned gap;
        @(negedge clk);
        gap = idle_len();
        if (gap != 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.op          = op;
        req_ch.remote_slot = slot;
        req_ch.command     = cmd;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (op == rtsbf_pkg::OP_SEND)
            queue_frame(slot, cmd);
        else
            bump_code(slot);
    endtask

    // Drop the request, let the frames drain, then give the pipe time to settle.
    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (frame_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rtsbf_pkg::CFG_IDX_W-1:0] index,
                             input logic [rtsbf_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = index;
        cfg_ch.data  = data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (index == rtsbf_pkg::REG_KEY)
            key_byte = data[7:0];
        else if (index == rtsbf_pkg::REG_BASE)
            base_id = data;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Frame sink: random stall pattern, held open while quiet.
    always @(negedge clk)
    begin
        if (sink_left == 0)
        begin
            if (quiet || !sink_open)
            begin
                sink_open = 1'b1;
                sink_left = quiet ? 8 : $urandom_range(1, 24);
            end
            else
            begin
                sink_open = 1'b0;
                sink_left = gap_len();
            end
        end
        sink_left    = sink_left - 1;
        rsp_ch.ready = sink_open;
    end

    // ------------------------------------------------------------------
    // Checker and watchdog
    // ------------------------------------------------------------------
    task automatic flag_error(input string what, input frame_word_t exp_w,
                              input logic [7:0] got_value, input logic got_last);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s: expected byte %02h last %b, got byte %02h last %b",
                     $realtime, what, exp_w.value, exp_w.last, got_value, got_last);
    endtask

    always @(posedge clk)
    begin
        frame_word_t exp_w;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (frame_due.size() == 0)
            begin
                exp_w = '0;
                flag_error("unexpected frame word", exp_w, rsp_ch.frame_byte,
                           rsp_ch.last_byte);
            end
            else
            begin
                exp_w = frame_due.pop_front();
                if (rsp_ch.frame_byte !== exp_w.value || rsp_ch.last_byte !== exp_w.last)
                    flag_error("frame word mismatch", exp_w, rsp_ch.frame_byte,
                               rsp_ch.last_byte);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("rts_blind_frame_builder_core_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_frames();
        send_word(rtsbf_pkg::OP_SEND, 4'd1, 4'd0);
        send_word(rtsbf_pkg::OP_SEND, 4'd9, 4'd15);
        send_word(rtsbf_pkg::OP_SEND, 4'd5, 4'ha);
    endtask

    // Slots outside the table: zero rolling code on send, advance does nothing.
    task automatic test_slot_range();
        send_word(rtsbf_pkg::OP_SEND, 4'd0, 4'd3);
        send_word(rtsbf_pkg::OP_ADVANCE, 4'd0, 4'd0);
        send_word(rtsbf_pkg::OP_ADVANCE, 4'd15, 4'd9);
        send_word(rtsbf_pkg::OP_SEND, 4'd0, 4'd3);
        send_word(rtsbf_pkg::OP_SEND, 4'd15, 4'd12);
        send_word(rtsbf_pkg::OP_SEND, 4'd10, 4'd1);
    endtask

    task automatic test_rolling_advance();
        repeat (3) send_word(rtsbf_pkg::OP_ADVANCE, 4'd3, 4'd6);
        send_word(rtsbf_pkg::OP_SEND, 4'd3, 4'd2);
        send_word(rtsbf_pkg::OP_SEND, 4'd4, 4'd2);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        write_reg(rtsbf_pkg::REG_KEY, 24'h000000);
        write_reg(rtsbf_pkg::REG_BASE, 24'h000000);
        send_word(rtsbf_pkg::OP_SEND, 4'd1, 4'd8);
        wait_idle();
        write_reg(rtsbf_pkg::REG_KEY, 24'hffffff);
        write_reg(rtsbf_pkg::REG_BASE, 24'hffffff);
        send_word(rtsbf_pkg::OP_SEND, 4'd9, 4'd7);
        send_word(rtsbf_pkg::OP_SEND, 4'd1, 4'd15);
        wait_idle();
        write_reg(REG_SPARE, 24'(24'h123456));
        write_reg(REG_TOP, 24'h00ff00);
        send_word(rtsbf_pkg::OP_SEND, 4'd2, 4'd1);
        wait_idle();
        // base plus top slot rolls the id over to zero
        write_reg(rtsbf_pkg::REG_KEY, 24'h3c005a);
        write_reg(rtsbf_pkg::REG_BASE, 24'hfffff7);
        send_word(rtsbf_pkg::OP_SEND, 4'd9, 4'd4);
    endtask

    // Back-to-back advances on one slot, with a send on either side.
    task automatic test_rolling_burst();
        quiet = 1'b1;
        send_word(rtsbf_pkg::OP_SEND, 4'd9, 4'd1);
        repeat (12) send_word(rtsbf_pkg::OP_ADVANCE, 4'd9, 4'd0);
        send_word(rtsbf_pkg::OP_SEND, 4'd9, 4'd2);
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [3:0]      slot;
        logic [23:0]     base;
        rtsbf_pkg::op_t  op;
        for (int phase = 0; phase < 5; phase++)
        begin
            wait_idle();
            case ($urandom_range(0, 2))
                0:       base = 24'($urandom);
                1:       base = 24'hfffff0 + 24'($urandom_range(0, 15));
                default: base = 24'($urandom_range(0, 255));
            endcase
            write_reg(rtsbf_pkg::REG_KEY, 24'($urandom));
            write_reg(rtsbf_pkg::REG_BASE, base);
            for (int n = 0; n < 70; n++)
            begin
                if ($urandom_range(0, 99) < 3)
                    quiet = ~quiet;
                op = ($urandom_range(0, 9) < 3) ? rtsbf_pkg::OP_ADVANCE : rtsbf_pkg::OP_SEND;
                if ($urandom_range(0, 9) == 0)
                    slot = ($urandom_range(0, 6) == 0) ? 4'd0 : 4'($urandom_range(10, 15));
                else
                    slot = 4'($urandom_range(1, REMOTE_SLOTS));
                send_word(op, slot, 4'($urandom_range(0, 15)));
            end
            quiet = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        err_count   = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        sink_open   = 1'b0;
        sink_left   = 0;
        key_byte    = rtsbf_pkg::KEY_RESET;
        base_id     = 24'h000000;
        for (int i = 1; i <= REMOTE_SLOTS; i++)
            roll_code[i] = 16'h0000;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.op          = rtsbf_pkg::OP_SEND;
        req_ch.remote_slot = 4'd0;
        req_ch.command     = 4'd0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = rtsbf_pkg::REG_KEY;
        cfg_ch.data        = '0;
        rsp_ch.ready       = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_frames();
        test_slot_range();
        test_rolling_advance();
        test_register_extremes();
        test_rolling_burst();
        test_random_traffic();

        wait_idle();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("rts_blind_frame_builder_core_tb: PASS");
        else
            $display("rts_blind_frame_builder_core_tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
src/rtsbf_pkg.sv
src/rtsbf_in_if.sv
src/rtsbf_out_if.sv
src/rtsbf_cfg_if.sv
src/rtsbf_serializer.sv
src/rts_blind_frame_builder_core.sv
bench/rts_blind_frame_builder_core_tb.sv
